@@ rtl/lfpf_pkg.sv @@
// Shared types and constants for the leg fork point finder.
// No dependencies; every other file imports this package.
package lfpf_pkg;

  // Fixed field widths of the streaming channels and registers
  localparam int PIXEL_W = 8;
  localparam int OUT_W   = 12;
  localparam int CFG_W   = 13;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // A pixel is white only at full level
  localparam logic [PIXEL_W-1:0] WHITE_LEVEL = 8'hFF;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // One result item
  typedef struct packed {
    logic [OUT_W-1:0] fork_col;
    logic [OUT_W-1:0] fork_row;
  } fork_res_t;

endpackage

@@ rtl/lfpf_if.sv @@
// Valid/ready stream interfaces for pixels in and fork points out.
// Depends on lfpf_pkg for field widths.
interface lfpf_pix_if;
  import lfpf_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lfpf_fork_if;
  import lfpf_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] fork_col;
  logic [OUT_W-1:0] fork_row;

  modport source (output valid, output fork_col, output fork_row, input ready);
  modport sink   (input valid, input fork_col, input fork_row, output ready);
endinterface

@@ rtl/lfpf_regs.sv @@
// APB register file: image_width at 0x0, image_height at 0x4.
// Drives clamped dimensions to the tracker. Depends on lfpf_pkg.
module lfpf_regs #(
  parameter int MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfpf_pkg::APB_AW-1:0] paddr,
  input  logic [lfpf_pkg::APB_DW-1:0] pwdata,
  output logic [lfpf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [$clog2(MAX_DIM+1)-1:0] width_eff,
  output logic [$clog2(MAX_DIM+1)-1:0] height_eff
);
  import lfpf_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  // Read back the stored value
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height);
    endcase
  end

  // Saturate dimensions to 1..MAX_DIM
  always_comb begin
    if (image_width == '0)                      width_eff = DW'(1);
    else if (32'(image_width) > MAX_DIM)        width_eff = DW'(MAX_DIM);
    else                                        width_eff = DW'(image_width);
    if (image_height == '0)                     height_eff = DW'(1);
    else if (32'(image_height) > MAX_DIM)       height_eff = DW'(MAX_DIM);
    else                                        height_eff = DW'(image_height);
  end

endmodule

@@ rtl/lfpf_tracker.sv @@
// Per-pixel search state: row scan accumulators, edges and centre.
// Updates once per stepped pixel and flags the pixel that ends the search.
// Depends on lfpf_pkg.
module lfpf_tracker #(
  parameter int MAX_DIM        = 4096,
  parameter int NEIGHBOUR_SPAN = 10,
  parameter int MAJORITY_COUNT = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         white,
  input  logic                         frame_start,
  input  logic [$clog2(MAX_DIM+1)-1:0] width_eff,
  input  logic [$clog2(MAX_DIM+1)-1:0] height_eff,
  output logic                         emit,
  output lfpf_pkg::fork_res_t          res
);
  import lfpf_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);
  localparam int LW = $clog2(NEIGHBOUR_SPAN + 1);
  localparam int SW = CW + 8;

  // Stored state
  logic [CW-1:0] col_count, row_index, centre_col, centre_row;
  logic [CW-1:0] left_edge_col, right_edge_col;
  logic [LW-1:0] left_white_count;
  logic          centre_is_white;
  logic [CW-1:0] nearest_left_white, nearest_right_white;
  logic          nearest_left_seen, nearest_right_seen;
  logic          search_done;

  // Next values
  logic [CW-1:0] col_count_next, row_index_next, centre_col_next, centre_row_next;
  logic [CW-1:0] left_edge_col_next, right_edge_col_next;
  logic [LW-1:0] left_white_count_next;
  logic          centre_is_white_next;
  logic [CW-1:0] nearest_left_white_next, nearest_right_white_next;
  logic          nearest_left_seen_next, nearest_right_seen_next;
  logic          search_done_next;

  logic          examined;
  logic          row_end;
  logic          stop;
  logic [CW:0]   edge_sum;

  always_comb begin
    // Start from stored state, or from frame defaults on frame start
    col_count_next           = col_count;
    row_index_next           = row_index;
    centre_col_next          = centre_col;
    centre_row_next          = centre_row;
    left_edge_col_next       = left_edge_col;
    right_edge_col_next      = right_edge_col;
    left_white_count_next    = left_white_count;
    centre_is_white_next     = centre_is_white;
    nearest_left_white_next  = nearest_left_white;
    nearest_left_seen_next   = nearest_left_seen;
    nearest_right_white_next = nearest_right_white;
    nearest_right_seen_next  = nearest_right_seen;
    search_done_next         = search_done;
    if (frame_start) begin
      col_count_next           = '0;
      row_index_next           = '0;
      centre_col_next          = CW'(width_eff >> 1);
      centre_row_next          = CW'(height_eff - DW'(1));
      left_edge_col_next       = '0;
      right_edge_col_next      = '0;
      left_white_count_next    = '0;
      centre_is_white_next     = 1'b0;
      nearest_left_white_next  = '0;
      nearest_left_seen_next   = 1'b0;
      nearest_right_white_next = '0;
      nearest_right_seen_next  = 1'b0;
      search_done_next         = 1'b0;
    end

    examined = (DW'(row_index_next) + DW'(1)) < height_eff;
    row_end  = (DW'(col_count_next) + DW'(1)) >= width_eff;
    stop     = 1'b0;
    edge_sum = '0;
    emit     = 1'b0;

    if (!search_done_next) begin
      // Accumulate the row scan around the centre column
      if (examined && white) begin
        if (col_count_next == centre_col_next) centre_is_white_next = 1'b1;
        if (col_count_next < centre_col_next) begin
          nearest_left_white_next = col_count_next;
          nearest_left_seen_next  = 1'b1;
          if (SW'(col_count_next) + SW'(NEIGHBOUR_SPAN) >= SW'(centre_col_next))
            left_white_count_next = left_white_count_next + LW'(1);
        end
        if (col_count_next > centre_col_next && !nearest_right_seen_next) begin
          nearest_right_white_next = col_count_next;
          nearest_right_seen_next  = 1'b1;
        end
      end

      if (!row_end) begin
        col_count_next = col_count_next + CW'(1);
      end else begin
        col_count_next = '0;
        // Examined row end: recentre and move edges if the centre was white
        if (examined) begin
          if (centre_is_white_next) begin
            centre_row_next = CW'(height_eff - DW'(1) - DW'(row_index_next));
            if (32'(left_white_count_next) > MAJORITY_COUNT) begin
              left_edge_col_next = centre_col_next;
              if (nearest_right_seen_next) right_edge_col_next = nearest_right_white_next;
            end else begin
              right_edge_col_next = centre_col_next;
              if (nearest_left_seen_next) left_edge_col_next = nearest_left_white_next;
            end
            edge_sum        = {1'b0, left_edge_col_next} + {1'b0, right_edge_col_next};
            centre_col_next = edge_sum[CW:1];
          end
          left_white_count_next    = '0;
          centre_is_white_next     = 1'b0;
          nearest_left_white_next  = '0;
          nearest_left_seen_next   = 1'b0;
          nearest_right_white_next = '0;
          nearest_right_seen_next  = 1'b0;
          if (centre_col_next == left_edge_col_next ||
              centre_col_next == right_edge_col_next) stop = 1'b1;
        end
        if (!examined) stop = 1'b1;
        // Advance the row, or finish and report
        if (stop) begin
          search_done_next = 1'b1;
          emit             = 1'b1;
        end else begin
          row_index_next = row_index_next + CW'(1);
        end
      end
    end

    res.fork_col = OUT_W'(centre_col_next);
    res.fork_row = OUT_W'(centre_row_next);
  end

  // Commit state on each stepped pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count           <= '0;
      row_index           <= '0;
      centre_col          <= '0;
      centre_row          <= '0;
      left_edge_col       <= '0;
      right_edge_col      <= '0;
      left_white_count    <= '0;
      centre_is_white     <= 1'b0;
      nearest_left_white  <= '0;
      nearest_left_seen   <= 1'b0;
      nearest_right_white <= '0;
      nearest_right_seen  <= 1'b0;
      search_done         <= 1'b1;
    end else if (step) begin
      col_count           <= col_count_next;
      row_index           <= row_index_next;
      centre_col          <= centre_col_next;
      centre_row          <= centre_row_next;
      left_edge_col       <= left_edge_col_next;
      right_edge_col      <= right_edge_col_next;
      left_white_count    <= left_white_count_next;
      centre_is_white     <= centre_is_white_next;
      nearest_left_white  <= nearest_left_white_next;
      nearest_left_seen   <= nearest_left_seen_next;
      nearest_right_white <= nearest_right_white_next;
      nearest_right_seen  <= nearest_right_seen_next;
      search_done         <= search_done_next;
    end
  end

endmodule

@@ rtl/leg_fork_point_finder_unit.sv @@
// Top level of the leg fork point finder: input register, tracker, result register.
// Depends on lfpf_pkg, lfpf_if, lfpf_regs and lfpf_tracker.
//
//   channel    dir  handshake       payload
//   pix_in     in   valid/ready     pixel[7:0], frame_start
//   fork_out   out  valid/ready     fork_col[11:0], fork_row[11:0]
//   apb        in   psel/penable    paddr[2:0], pwdata/prdata[31:0], pready
//
// One pixel per cycle sustained unless a pending result stalls the input; a pixel
// waits in the input register, and its result, if any, is loaded into the result
// register as the pixel steps out. The tracker update between them is combinational.
// Reset (synchronous) leaves the search done: pixels are dropped until frame_start.
// A pending result stalls the input only when the next pixel would also report.
module leg_fork_point_finder_unit #(
  parameter int MAX_DIM        = 4096,
  parameter int NEIGHBOUR_SPAN = 10,
  parameter int MAJORITY_COUNT = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  lfpf_pix_if.sink                    pix_in,
  lfpf_fork_if.source                 fork_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfpf_pkg::APB_AW-1:0] paddr,
  input  logic [lfpf_pkg::APB_DW-1:0] pwdata,
  output logic [lfpf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lfpf_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DW-1:0] width_eff, height_eff;
  logic          s1_valid, s1_white, s1_frame_start;
  logic          advance, step, emit;
  fork_res_t     res, out_res;
  logic          out_valid;

  lfpf_regs #(.MAX_DIM(MAX_DIM)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  // Hold the input register only when its result cannot be placed
  assign advance      = !(s1_valid && emit && out_valid && !fork_out.ready);
  assign step         = s1_valid && advance;
  assign pix_in.ready = !s1_valid || advance;

  // Capture the incoming transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.valid && pix_in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      s1_white       <= (pix_in.pixel == WHITE_LEVEL);
      s1_frame_start <= pix_in.frame_start;
    end
  end

  lfpf_tracker #(
    .MAX_DIM        (MAX_DIM),
    .NEIGHBOUR_SPAN (NEIGHBOUR_SPAN),
    .MAJORITY_COUNT (MAJORITY_COUNT)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .white       (s1_white),
    .frame_start (s1_frame_start),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .emit        (emit),
    .res         (res)
  );

  // Result register: load on a reporting pixel, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (fork_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) out_res <= res;
  end

  assign fork_out.valid    = out_valid;
  assign fork_out.fork_col = out_res.fork_col;
  assign fork_out.fork_row = out_res.fork_row;

endmodule
